// ----- sv/ialp_pkg.sv -----
// Package with types and constants for the address literal parser.
package ialp_pkg;

    typedef struct packed {
        logic [7:0]  character;
        logic [15:0] port;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [15:0] port_out;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_START_COLON = 3'd1,
        PH_AFTER_COLON = 3'd2,
        PH_AFTER_GAP   = 3'd3,
        PH_IN_GROUP    = 3'd4,
        PH_TAIL        = 3'd5
    } six_phase_t;

    // Character class produced by the front part.
    typedef struct packed {
        logic       is_term;
        logic       is_dec;
        logic       is_hex;
        logic       is_colon;
        logic       is_dot;
        logic [3:0] digit;
        logic [15:0] port;
    } class_t;

    localparam int unsigned QueueDepth = 2;

    localparam logic [7:0] CharColon = 8'h3a;
    localparam logic [7:0] CharDot   = 8'h2e;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowF  = 8'h66;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;
    localparam logic [4:0] FullBytes = 5'd16;
    localparam logic [4:0] TailLimit = 5'd12;
    localparam logic [4:0] PairLimit = 5'd14;
    localparam logic [9:0] OctetMax  = 10'd255;

endpackage

// ----- sv/ialp_front.sv -----
// Front part: accepts characters and classifies them.
module ialp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ialp_pkg::in_item_t s_data,
    output logic              c_valid,
    input  logic              c_ready,
    output ialp_pkg::class_t  c_data
);
    logic             valid_reg, valid_next;
    ialp_pkg::class_t data_reg, data_next;
    logic [7:0]       ch;

    assign s_ready = !valid_reg || c_ready;
    assign ch      = s_data.character;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_ready) begin
            valid_next        = s_valid;
            data_next.is_term = (ch == 8'h00);
            data_next.is_dec  = (ch >= ialp_pkg::CharZero) && (ch <= ialp_pkg::CharNine);
            data_next.is_colon = (ch == ialp_pkg::CharColon);
            data_next.is_dot   = (ch == ialp_pkg::CharDot);
            data_next.port     = s_data.port;
            if (data_next.is_dec) begin
                data_next.is_hex = 1'b1;
                data_next.digit  = 4'(ch - ialp_pkg::CharZero);
            end else if ((ch >= ialp_pkg::CharLowA) && (ch <= ialp_pkg::CharLowF)) begin
                data_next.is_hex = 1'b1;
                data_next.digit  = 4'(ch - ialp_pkg::CharLowA + 8'd10);
            end else if ((ch >= ialp_pkg::CharUpA) && (ch <= ialp_pkg::CharUpF)) begin
                data_next.is_hex = 1'b1;
                data_next.digit  = 4'(ch - ialp_pkg::CharUpA + 8'd10);
            end else begin
                data_next.is_hex = 1'b0;
                data_next.digit  = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign c_valid = valid_reg;
    assign c_data  = data_reg;
endmodule

// ----- sv/ialp_queue.sv -----
// Short queue between the front and back parts.
module ialp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             w_valid,
    output logic             w_ready,
    input  ialp_pkg::class_t w_data,
    output logic             r_valid,
    input  logic             r_ready,
    output ialp_pkg::class_t r_data
);
    localparam int unsigned AddrW = $clog2(ialp_pkg::QueueDepth);

    ialp_pkg::class_t mem_reg [ialp_pkg::QueueDepth];
    logic [AddrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AddrW:0]   cnt_reg, cnt_next;
    logic             push, pop;

    assign w_ready = (cnt_reg != AddrW'(0) + (AddrW+1)'(ialp_pkg::QueueDepth));
    assign r_valid = (cnt_reg != '0);
    assign r_data  = mem_reg[rd_reg];
    assign push    = w_valid && w_ready;
    assign pop     = r_valid && r_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AddrW'(ialp_pkg::QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == AddrW'(ialp_pkg::QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= w_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AddrW+1)'(ialp_pkg::QueueDepth))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not rise on push");
    a_empty_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !pop)
        else $error("pop from empty queue");
`endif
endmodule

// ----- sv/ialp_back.sv -----
// Back part: runs both parsers per character and builds the result at the terminator.
module ialp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               c_valid,
    output logic               c_ready,
    input  ialp_pkg::class_t   c_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ialp_pkg::out_item_t m_data
);
    logic [7:0] q_oct_reg [4];
    logic [7:0] q_oct_next [4];
    logic [1:0] q_idx_reg, q_idx_next;
    logic [8:0] q_val_reg, q_val_next;
    logic [1:0] q_dig_reg, q_dig_next;
    logic       q_fail_reg, q_fail_next;

    logic [7:0]  s_bytes_reg [16];
    logic [7:0]  s_bytes_next [16];
    logic [4:0]  s_fill_reg, s_fill_next;
    logic [4:0]  gap_pos_reg, gap_pos_next;
    logic        gap_seen_reg, gap_seen_next;
    logic [15:0] g_hex_reg, g_hex_next;
    logic [9:0]  g_dec_reg, g_dec_next;
    logic [2:0]  g_dig_reg, g_dig_next;
    logic        g_deco_reg, g_deco_next;
    logic [1:0]  g_tail_reg, g_tail_next;
    ialp_pkg::six_phase_t ph_reg, ph_next;
    logic        s_fail_reg, s_fail_next;

    logic                 out_valid_reg, out_valid_next;
    ialp_pkg::out_item_t  out_reg, out_next;

    logic       take;
    logic [9:0] qv_ext, tv_ext;
    logic [4:0] fill_f, tail_n, lead_n;
    logic       six_ok, quad_ok;
    logic [7:0] bytes_f [16];
    logic [7:0] res [16];
    logic [4:0] idx, src;
    logic [3:0] d;

    assign c_ready = !out_valid_reg || m_ready;
    assign take    = c_valid && c_ready;
    assign d       = c_data.digit;
    assign qv_ext  = {1'b0, q_val_reg} * 10'd10 + 10'(d);
    assign tv_ext  = g_dec_reg * 10'd10 + 10'(d);

    // Per-character parser update.
    always_comb begin
        q_oct_next   = q_oct_reg;
        q_idx_next   = q_idx_reg;
        q_val_next   = q_val_reg;
        q_dig_next   = q_dig_reg;
        q_fail_next  = q_fail_reg;
        s_bytes_next = s_bytes_reg;
        s_fill_next  = s_fill_reg;
        gap_pos_next = gap_pos_reg;
        gap_seen_next = gap_seen_reg;
        g_hex_next   = g_hex_reg;
        g_dec_next   = g_dec_reg;
        g_dig_next   = g_dig_reg;
        g_deco_next  = g_deco_reg;
        g_tail_next  = g_tail_reg;
        ph_next      = ph_reg;
        s_fail_next  = s_fail_reg;

        if (!q_fail_reg) begin
            if (c_data.is_dec) begin
                if ((q_dig_reg == 2'd3) || (qv_ext > ialp_pkg::OctetMax)) begin
                    q_fail_next = 1'b1;
                end else begin
                    q_val_next = qv_ext[8:0];
                    q_dig_next = q_dig_reg + 1'b1;
                end
            end else if (c_data.is_dot) begin
                if ((q_dig_reg == 2'd0) || (q_idx_reg == 2'd3)) begin
                    q_fail_next = 1'b1;
                end else begin
                    q_oct_next[q_idx_reg] = q_val_reg[7:0];
                    q_idx_next = q_idx_reg + 1'b1;
                    q_val_next = '0;
                    q_dig_next = '0;
                end
            end else begin
                q_fail_next = 1'b1;
            end
        end

        if (!s_fail_reg) begin
            case (ph_reg)
                ialp_pkg::PH_START, ialp_pkg::PH_AFTER_COLON,
                ialp_pkg::PH_AFTER_GAP, ialp_pkg::PH_START_COLON: begin
                    if (c_data.is_colon && (ph_reg == ialp_pkg::PH_START)) begin
                        ph_next = ialp_pkg::PH_START_COLON;
                    end else if (ph_reg == ialp_pkg::PH_START_COLON) begin
                        if (c_data.is_colon) begin
                            gap_seen_next = 1'b1;
                            gap_pos_next  = '0;
                            ph_next       = ialp_pkg::PH_AFTER_GAP;
                        end else begin
                            s_fail_next = 1'b1;
                        end
                    end else if (c_data.is_colon && (ph_reg == ialp_pkg::PH_AFTER_COLON)) begin
                        if (gap_seen_reg) begin
                            s_fail_next = 1'b1;
                        end else begin
                            gap_seen_next = 1'b1;
                            gap_pos_next  = s_fill_reg;
                            ph_next       = ialp_pkg::PH_AFTER_GAP;
                        end
                    end else if (c_data.is_hex) begin
                        g_hex_next  = {12'd0, d};
                        g_deco_next = c_data.is_dec;
                        g_dec_next  = c_data.is_dec ? 10'(d) : 10'd0;
                        g_dig_next  = 3'd1;
                        ph_next     = ialp_pkg::PH_IN_GROUP;
                    end else begin
                        s_fail_next = 1'b1;
                    end
                end
                ialp_pkg::PH_IN_GROUP: begin
                    if (c_data.is_hex) begin
                        if (g_dig_reg >= 3'd4) begin
                            s_fail_next = 1'b1;
                        end else begin
                            g_hex_next = {g_hex_reg[11:0], d};
                            if (!c_data.is_dec) begin
                                g_deco_next = 1'b0;
                            end else if (g_dig_reg < 3'd3) begin
                                g_dec_next = tv_ext;
                            end
                            g_dig_next = g_dig_reg + 1'b1;
                        end
                    end else if (c_data.is_colon) begin
                        if (s_fill_reg > ialp_pkg::PairLimit) begin
                            s_fail_next = 1'b1;
                        end else begin
                            s_bytes_next[s_fill_reg[3:0]]        = g_hex_reg[15:8];
                            s_bytes_next[4'(s_fill_reg + 5'd1)] = g_hex_reg[7:0];
                            s_fill_next = s_fill_reg + 5'd2;
                            ph_next     = ialp_pkg::PH_AFTER_COLON;
                        end
                    end else if (c_data.is_dot) begin
                        if ((s_fill_reg > ialp_pkg::TailLimit) || !g_deco_reg ||
                            (g_dig_reg > 3'd3) || (g_dec_reg > ialp_pkg::OctetMax)) begin
                            s_fail_next = 1'b1;
                        end else begin
                            s_bytes_next[s_fill_reg[3:0]] = g_dec_reg[7:0];
                            g_tail_next = 2'd1;
                            g_dec_next  = '0;
                            g_dig_next  = '0;
                            ph_next     = ialp_pkg::PH_TAIL;
                        end
                    end else begin
                        s_fail_next = 1'b1;
                    end
                end
                ialp_pkg::PH_TAIL: begin
                    if (c_data.is_dec) begin
                        if ((g_dig_reg >= 3'd3) || (tv_ext > ialp_pkg::OctetMax)) begin
                            s_fail_next = 1'b1;
                        end else begin
                            g_dec_next = tv_ext;
                            g_dig_next = g_dig_reg + 1'b1;
                        end
                    end else if (c_data.is_dot) begin
                        if ((g_dig_reg == 3'd0) || (g_tail_reg == 2'd3)) begin
                            s_fail_next = 1'b1;
                        end else begin
                            s_bytes_next[4'(s_fill_reg + 5'(g_tail_reg))] = g_dec_reg[7:0];
                            g_tail_next = g_tail_reg + 1'b1;
                            g_dec_next  = '0;
                            g_dig_next  = '0;
                        end
                    end else begin
                        s_fail_next = 1'b1;
                    end
                end
                default: begin
                    s_fail_next = 1'b1;
                end
            endcase
        end
    end

    // Terminator evaluation: close the pending group, then expand the gap.
    always_comb begin
        bytes_f = s_bytes_reg;
        fill_f  = s_fill_reg;
        six_ok  = !s_fail_reg;
        case (ph_reg)
            ialp_pkg::PH_AFTER_GAP: begin
                six_ok = six_ok;
            end
            ialp_pkg::PH_IN_GROUP: begin
                if (s_fill_reg > ialp_pkg::PairLimit) begin
                    six_ok = 1'b0;
                end else begin
                    bytes_f[s_fill_reg[3:0]]        = g_hex_reg[15:8];
                    bytes_f[4'(s_fill_reg + 5'd1)] = g_hex_reg[7:0];
                    fill_f = s_fill_reg + 5'd2;
                end
            end
            ialp_pkg::PH_TAIL: begin
                if ((g_tail_reg != 2'd3) || (g_dig_reg == 3'd0)) begin
                    six_ok = 1'b0;
                end else begin
                    bytes_f[4'(s_fill_reg + 5'd3)] = g_dec_reg[7:0];
                    fill_f = s_fill_reg + 5'd4;
                end
            end
            default: begin
                six_ok = 1'b0;
            end
        endcase
        if (gap_seen_reg) begin
            if ((fill_f >= ialp_pkg::FullBytes) || (gap_pos_reg > fill_f)) begin
                six_ok = 1'b0;
            end
        end else if (fill_f != ialp_pkg::FullBytes) begin
            six_ok = 1'b0;
        end
        tail_n = fill_f - gap_pos_reg;
        lead_n = ialp_pkg::FullBytes - tail_n;
        for (int i = 0; i < 16; i++) begin
            idx = 5'(i);
            src = gap_pos_reg + idx - lead_n;
            if (!gap_seen_reg || (idx < gap_pos_reg)) begin
                res[i] = bytes_f[i];
            end else if (idx < lead_n) begin
                res[i] = 8'd0;
            end else begin
                res[i] = bytes_f[src[3:0]];
            end
        end
        quad_ok = !q_fail_reg && (q_idx_reg == 2'd3) && (q_dig_reg != 2'd0);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (take && c_data.is_term) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (quad_ok) begin
                out_next.valid_res   = 1'b1;
                out_next.address_low = {32'd0, q_oct_reg[0], q_oct_reg[1], q_oct_reg[2],
                                        q_val_reg[7:0]};
                out_next.port_out    = c_data.port;
            end else if (six_ok) begin
                out_next.valid_res    = 1'b1;
                out_next.is_ipv6      = 1'b1;
                out_next.address_high = {res[0], res[1], res[2], res[3],
                                         res[4], res[5], res[6], res[7]};
                out_next.address_low  = {res[8], res[9], res[10], res[11],
                                         res[12], res[13], res[14], res[15]};
                out_next.port_out     = c_data.port;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && c_data.is_term)) begin
            for (int i = 0; i < 4; i++) q_oct_reg[i] <= '0;
            for (int i = 0; i < 16; i++) s_bytes_reg[i] <= '0;
            q_idx_reg    <= '0;
            q_val_reg    <= '0;
            q_dig_reg    <= '0;
            q_fail_reg   <= 1'b0;
            s_fill_reg   <= '0;
            gap_pos_reg  <= '0;
            gap_seen_reg <= 1'b0;
            g_hex_reg    <= '0;
            g_dec_reg    <= '0;
            g_dig_reg    <= '0;
            g_deco_reg   <= 1'b0;
            g_tail_reg   <= '0;
            ph_reg       <= ialp_pkg::PH_START;
            s_fail_reg   <= 1'b0;
        end else if (take) begin
            q_oct_reg    <= q_oct_next;
            s_bytes_reg  <= s_bytes_next;
            q_idx_reg    <= q_idx_next;
            q_val_reg    <= q_val_next;
            q_dig_reg    <= q_dig_next;
            q_fail_reg   <= q_fail_next;
            s_fill_reg   <= s_fill_next;
            gap_pos_reg  <= gap_pos_next;
            gap_seen_reg <= gap_seen_next;
            g_hex_reg    <= g_hex_next;
            g_dec_reg    <= g_dec_next;
            g_dig_reg    <= g_dig_next;
            g_deco_reg   <= g_deco_next;
            g_tail_reg   <= g_tail_next;
            ph_reg       <= ph_next;
            s_fail_reg   <= s_fail_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result changed");
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && c_data.is_term) |=> (ph_reg == ialp_pkg::PH_START && !s_fail_reg))
        else $error("parser not cleared after terminator");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (m_data.port_out == '0 && !m_data.is_ipv6))
        else $error("invalid result carries data");
`endif
endmodule

// ----- sv/ip_address_literal_parser.sv -----
// Top level of the streaming IPv4 / IPv6 address literal parser.
// Throughput: one character transfer per cycle, sustained, while results are taken.
// A terminator's result passes the classifier register, a queue slot and
// the result register before it is offered on m_data.
// Reset: aresetn is synchronous and active low; it empties the queue, drops
// any pending result and returns both parsers to the start of a literal.
module ip_address_literal_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ialp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ialp_pkg::out_item_t m_data
);
    // The front classifies each byte; the queue decouples it from the parsers.
    logic             f_valid, f_ready, b_valid, b_ready;
    ialp_pkg::class_t f_data, b_data;

    ialp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .c_valid(f_valid), .c_ready(f_ready), .c_data(f_data)
    );

    ialp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
        .r_valid(b_valid), .r_ready(b_ready), .r_data(b_data)
    );

    // The back part runs both parsers and holds one result for transfer.
    ialp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .c_valid(b_valid), .c_ready(b_ready), .c_data(b_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
